@@ rtl/core/u8cc_pkg.sv @@
// Shared types and constants for the UTF-8 content classifier.
// Holds the input and result payload structs and the verdict reason codes.
// No dependencies.
`default_nettype none

package u8cc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       needs_conversion;
    logic       bom_present;
    logic [2:0] verdict_reason;
  } out_t;

  typedef enum logic [2:0] {
    ReasonConvert  = 3'd0,
    ReasonNoMulti  = 3'd1,
    ReasonMarker   = 3'd2,
    ReasonLegacy   = 3'd3,
    ReasonBadLead  = 3'd4,
    ReasonTrunc    = 3'd5,
    ReasonBroken   = 3'd6
  } reason_e;

  localparam logic [7:0] BomByte0   = 8'hEF;
  localparam logic [7:0] BomByte1   = 8'hBB;
  localparam logic [7:0] BomByte2   = 8'hBF;
  localparam logic [7:0] MarkerLow  = 8'h10;
  localparam logic [7:0] MarkerHigh = 8'h13;
  localparam logic [7:0] HighBit    = 8'h80;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;

  localparam logic [1:0] BomLength  = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/utf8_content_classifier.sv @@
// Top level of the UTF-8 content classifier.
// Instantiates the input register, the scan stage and the result register.
// Depends on u8cc_pkg, u8cc_input_reg, u8cc_scan and u8cc_result_reg.
//
// Usage: a file streams in one byte per transfer on the input channel, with
// last_byte set on its final byte. Exactly one verdict comes out per file,
// on the output channel, after the final byte. Both channels use valid and
// stall; a transfer happens on a clock edge with valid high and stall low.
// The text_mode register is written over the configuration channel, which is
// always ready; write it only between files while the block is idle.
//
// Throughput is one byte per cycle while no last byte waits for the result
// register: a byte waits in the input register, the scan stage updates its
// per-file state on it, and a verdict is loaded into the result register,
// where it is offered. While the receiver stalls, the held verdict stays;
// bytes that cause no verdict keep flowing, and the next last byte waits in
// the input register until the result register frees up.
// Reset clears text_mode and all per-file state; the first byte after reset
// starts a new file.
`default_nettype none

module utf8_content_classifier
  import u8cc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic cfg_data_i
);

  logic text_mode_q;
  logic byte_valid;
  in_t  byte_q;
  logic advance;
  logic result_free;
  logic load_result;
  out_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_mode_q <= cfg_data_i;
    end
  end

  // Only a last byte needs room in the result register.
  assign advance     = byte_valid & (~byte_q.last_byte | result_free);
  assign load_result = advance & byte_q.last_byte;

  u8cc_input_reg u_input_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (byte_valid),
    .data_o     (byte_q)
  );

  u8cc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_mode_i (text_mode_q),
    .step_i      (advance),
    .byte_i      (byte_q),
    .result_o    (result)
  );

  u8cc_result_reg u_result_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_result),
    .result_i    (result),
    .free_o      (result_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/u8cc_input_reg.sv @@
// Input register stage of the UTF-8 content classifier.
// Captures one byte transfer and holds it until the scan stage consumes it.
// Depends on u8cc_pkg.
`default_nettype none

module u8cc_input_reg
  import u8cc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  input  wire logic advance_i,
  output logic      valid_o,
  output in_t       data_o
);

  logic valid_q, valid_d;
  in_t  data_q;
  logic accept;

  // The register is free when empty or when its byte moves on this cycle.
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/core/u8cc_scan.sv @@
// Per-file scan state of the UTF-8 content classifier.
// Runs the BOM reading and the plain UTF-8 reading on one byte per cycle
// while stepped, and forms the verdict on the last byte. Depends on u8cc_pkg.
`default_nettype none

module u8cc_scan
  import u8cc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic text_mode_i,
  input  wire logic step_i,
  input  wire in_t  byte_i,
  output out_t      result_o
);

  logic [1:0] pos_q, pos_d;
  logic       bom_match_q, bom_match_d;
  logic [1:0] cont_left_q, cont_left_d;
  logic       plain_failed_q, plain_failed_d;
  logic [2:0] plain_reason_q, plain_reason_d;
  logic       seq_broken_q, seq_broken_d;
  logic       multi_q, multi_d;
  logic       marker_q, marker_d;
  logic       high_q, high_d;

  logic [7:0] b;
  logic [7:0] bom_expect;
  logic       bom;
  logic [2:0] reason;

  assign b = byte_i.data_byte;

  always_comb begin
    case (pos_q)
      2'd0:    bom_expect = BomByte0;
      2'd1:    bom_expect = BomByte1;
      default: bom_expect = BomByte2;
    endcase
  end

  always_comb begin
    pos_d          = pos_q;
    bom_match_d    = bom_match_q;
    cont_left_d    = cont_left_q;
    plain_failed_d = plain_failed_q;
    plain_reason_d = plain_reason_q;
    seq_broken_d   = seq_broken_q;
    multi_d        = multi_q;
    marker_d       = marker_q;
    high_d         = high_q;

    // BOM reading: compare the first three bytes, then look at the body.
    if (pos_q < BomLength) begin
      if (b != bom_expect) begin
        bom_match_d = 1'b0;
      end
      pos_d = pos_q + 2'd1;
    end else begin
      if (b >= MarkerLow && b <= MarkerHigh) begin
        marker_d = 1'b1;
      end
      if (b >= HighBit) begin
        high_d = 1'b1;
      end
    end

    // Plain UTF-8 reading. Only the first failure reason is kept.
    if (cont_left_q != 2'd0) begin
      if ((b & ContMask) != HighBit) begin
        seq_broken_d = 1'b1;
      end
      cont_left_d = cont_left_q - 2'd1;
      if (cont_left_d == 2'd0) begin
        if (seq_broken_d) begin
          if (!plain_failed_q) begin
            plain_failed_d = 1'b1;
            plain_reason_d = ReasonBroken;
          end
        end else begin
          multi_d = 1'b1;
        end
        seq_broken_d = 1'b0;
      end
    end else if (text_mode_i && b >= HighBit && b <= BomByte2) begin
      if (!plain_failed_q) begin
        plain_failed_d = 1'b1;
        plain_reason_d = ReasonLegacy;
      end
    end else if (b >= ContMask) begin
      if ((b & Lead2Mask) == ContMask) begin
        cont_left_d = 2'd1;
      end else if ((b & Lead3Mask) == Lead2Mask) begin
        cont_left_d = 2'd2;
      end else if ((b & Lead4Mask) == Lead3Mask) begin
        cont_left_d = 2'd3;
      end else if (!plain_failed_q) begin
        plain_failed_d = 1'b1;
        plain_reason_d = ReasonBadLead;
      end
    end

    // Verdict from the updated state.
    bom = (pos_d == BomLength) & bom_match_d;
    if (bom) begin
      if (marker_d) begin
        reason = ReasonMarker;
      end else if (high_d) begin
        reason = ReasonConvert;
      end else begin
        reason = ReasonNoMulti;
      end
    end else if (plain_failed_d) begin
      reason = plain_reason_d;
    end else if (cont_left_d != 2'd0) begin
      reason = ReasonTrunc;
    end else if (multi_d) begin
      reason = ReasonConvert;
    end else begin
      reason = ReasonNoMulti;
    end
  end

  assign result_o.needs_conversion = (reason == ReasonConvert);
  assign result_o.bom_present      = bom;
  assign result_o.verdict_reason   = reason;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= 2'd0;
      bom_match_q    <= 1'b1;
      cont_left_q    <= 2'd0;
      plain_failed_q <= 1'b0;
      plain_reason_q <= ReasonConvert;
      seq_broken_q   <= 1'b0;
      multi_q        <= 1'b0;
      marker_q       <= 1'b0;
      high_q         <= 1'b0;
    end else if (step_i) begin
      if (byte_i.last_byte) begin
        // The file is done: the next byte starts a new one.
        pos_q          <= 2'd0;
        bom_match_q    <= 1'b1;
        cont_left_q    <= 2'd0;
        plain_failed_q <= 1'b0;
        plain_reason_q <= ReasonConvert;
        seq_broken_q   <= 1'b0;
        multi_q        <= 1'b0;
        marker_q       <= 1'b0;
        high_q         <= 1'b0;
      end else begin
        pos_q          <= pos_d;
        bom_match_q    <= bom_match_d;
        cont_left_q    <= cont_left_d;
        plain_failed_q <= plain_failed_d;
        plain_reason_q <= plain_reason_d;
        seq_broken_q   <= seq_broken_d;
        multi_q        <= multi_d;
        marker_q       <= marker_d;
        high_q         <= high_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/u8cc_result_reg.sv @@
// Result register of the UTF-8 content classifier.
// Holds one verdict until the receiver takes it. Depends on u8cc_pkg.
`default_nettype none

module u8cc_result_reg
  import u8cc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire out_t result_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic valid_q, valid_d;
  out_t data_q;

  // Free when empty or when the held verdict transfers this cycle.
  assign free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

@@ sim/u8cc_verdict_checker.sv @@
// Checker for the UTF-8 content classifier: watches the byte, verdict and config channels.
// Keeps its own per-file scan state, predicts one verdict per file and compares field by field.
// Depends on u8cc_pkg.
module u8cc_verdict_checker
  import u8cc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic cfg_data_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic       text_mode_q;
  logic [1:0] pos_cnt;
  logic       bom_ok;
  logic [1:0] cont_left;
  logic       plain_bad;
  reason_e    plain_why;
  logic       seq_broken;
  logic       multi_hit;
  logic       marker_hit;
  logic       high_hit;

  out_t expected_verdicts[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count_o++;
  endtask

  task automatic clear_file();
    pos_cnt    = '0;
    bom_ok     = 1'b1;
    cont_left  = '0;
    plain_bad  = 1'b0;
    plain_why  = ReasonConvert;
    seq_broken = 1'b0;
    multi_hit  = 1'b0;
    marker_hit = 1'b0;
    high_hit   = 1'b0;
  endtask

  // The plain UTF-8 reading keeps the reason of its first failure only.
  task automatic note_failure(input reason_e why);
    if (!plain_bad) begin
      plain_bad = 1'b1;
      plain_why = why;
    end
  endtask

  task automatic scan_byte(input in_t item);
    logic [7:0] b;
    logic [7:0] bom_want;
    logic       bom;
    reason_e    why;
    out_t       verdict;
    b = item.data_byte;

    if (pos_cnt < BomLength) begin
      case (pos_cnt)
        2'd0:    bom_want = BomByte0;
        2'd1:    bom_want = BomByte1;
        default: bom_want = BomByte2;
      endcase
      if (b != bom_want) bom_ok = 1'b0;
      pos_cnt = pos_cnt + 2'd1;
    end else begin
      if (b >= MarkerLow && b <= MarkerHigh) marker_hit = 1'b1;
      if (b >= HighBit) high_hit = 1'b1;
    end

    if (cont_left != 2'd0) begin
      // Bytes inside a sequence are never judged as leads or legacy bytes.
      if ((b & ContMask) != HighBit) seq_broken = 1'b1;
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (seq_broken) note_failure(ReasonBroken);
        else multi_hit = 1'b1;
        seq_broken = 1'b0;
      end
    end else if (text_mode_q && (b & ContMask) == HighBit) begin
      note_failure(ReasonLegacy);
    end else if (b >= ContMask) begin
      if ((b & Lead2Mask) == ContMask) cont_left = 2'd1;
      else if ((b & Lead3Mask) == Lead2Mask) cont_left = 2'd2;
      else if ((b & Lead4Mask) == Lead3Mask) cont_left = 2'd3;
      else note_failure(ReasonBadLead);
    end

    if (item.last_byte) begin
      bom = (pos_cnt == BomLength) && bom_ok;
      if (bom) begin
        if (marker_hit) why = ReasonMarker;
        else if (high_hit) why = ReasonConvert;
        else why = ReasonNoMulti;
      end else if (plain_bad) begin
        why = plain_why;
      end else if (cont_left != 2'd0) begin
        why = ReasonTrunc;
      end else if (multi_hit) begin
        why = ReasonConvert;
      end else begin
        why = ReasonNoMulti;
      end
      verdict.needs_conversion = (why == ReasonConvert);
      verdict.bom_present      = bom;
      verdict.verdict_reason   = why;
      expected_verdicts = {expected_verdicts, verdict};
      clear_file();
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      text_mode_q = 1'b0;
      clear_file();
      expected_verdicts.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) text_mode_q = cfg_data_i;

      // A verdict leaving now always belongs to a file that ended earlier.
      if (out_valid_i && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no file pending", 0, 1);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data_i.needs_conversion !== want.needs_conversion)
            report_mismatch("needs_conversion", want.needs_conversion,
                            out_data_i.needs_conversion);
          if (out_data_i.bom_present !== want.bom_present)
            report_mismatch("bom_present", want.bom_present, out_data_i.bom_present);
          if (out_data_i.verdict_reason !== want.verdict_reason)
            report_mismatch("verdict_reason", want.verdict_reason,
                            out_data_i.verdict_reason);
        end
      end

      if (in_valid_i && !in_stall_i) scan_byte(in_data_i);
    end
    pending_o = expected_verdicts.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the UTF-8 content classifier testbench: clock, reset, byte files, verdict stalls.
// Streams directed and random files under both text modes and gives the final verdict.
// Depends on u8cc_pkg, utf8_content_classifier and u8cc_verdict_checker.
module testbench
  import u8cc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 2000;
  localparam int PhaseBytes  = 240;
  localparam int PhaseCount  = 6;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_data_i  = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;
  logic cfg_ready_o;

  int fail_count;
  int pending;
  int bytes_sent;
  int idle_cycles;
  bit calm = 1'b0;

  logic [7:0] file_q[$];

  utf8_content_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  u8cc_verdict_checker verdict_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none at all during a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte(input int lo, input int hi);
    logic [7:0] v;
    v = 8'($urandom_range(hi, lo));
    return v;
  endfunction

  function automatic logic [7:0] bom_byte(input int idx);
    case (idx)
      0:       return BomByte0;
      1:       return BomByte1;
      default: return BomByte2;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    file_q = {file_q, b};
  endtask

  initial begin
    int   hold;
    logic stall_next;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        if (calm) begin
          stall_next = 1'b0;
          hold = 1;
        end else begin
          stall_next = ($urandom_range(0, 2) == 0);
          hold = stall_next ? pick_gap() + 1 : $urandom_range(1, 8);
        end
        out_stall_i <= stall_next;
      end
      hold--;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // Drains every pending verdict and lets the pipeline settle before a config write.
  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_text_mode(input logic value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_sequence();
    int n;
    n = $urandom_range(2, 4);
    case (n)
      2:       add_byte(pick_byte(8'hC0, 8'hDF));
      3:       add_byte(pick_byte(8'hE0, 8'hEF));
      default: add_byte(pick_byte(8'hF0, 8'hF7));
    endcase
    for (int i = 1; i < n; i++) add_byte(pick_byte(8'h80, 8'hBF));
  endtask

  task automatic add_text(input int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) add_sequence();
      else if ($urandom_range(0, 7) == 0) add_byte(pick_byte(8'h00, 8'h7F));
      else add_byte(pick_byte(8'h20, 8'h7E));
    end
  endtask

  task automatic make_file();
    int kind;
    int len;
    int r;
    int n;
    int bad_at;
    kind = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
    file_q.delete();
    if (kind < 15) begin
      for (int i = 0; i < 3; i++) add_byte(bom_byte(i));
      repeat ($urandom_range(0, len)) begin
        r = $urandom_range(0, 99);
        if (r < 8) add_byte(pick_byte(8'h10, 8'h13));
        else if (r < 30) add_byte(pick_byte(8'h80, 8'hFF));
        else if (r < 45) add_sequence();
        else add_byte(pick_byte(8'h00, 8'h7F));
      end
    end else if (kind < 22) begin
      // A partial or slightly wrong BOM, often shorter than three bytes.
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        add_byte(($urandom_range(0, 3) == 0) ? pick_byte(8'h00, 8'hFF) : bom_byte(i));
      if ($urandom_range(0, 1) == 0) add_text($urandom_range(0, 4));
    end else if (kind < 62) begin
      add_text(len);
    end else if (kind < 87) begin
      add_text($urandom_range(0, len));
      case ($urandom_range(0, 3))
        0: add_byte(pick_byte(8'h80, 8'hBF));
        1: add_byte(pick_byte(8'hF8, 8'hFF));
        2: begin
          n = $urandom_range(2, 4);
          bad_at = $urandom_range(1, n - 1);
          add_byte((n == 2) ? pick_byte(8'hC0, 8'hDF) :
                   (n == 3) ? pick_byte(8'hE0, 8'hEF) : pick_byte(8'hF0, 8'hF7));
          for (int i = 1; i < n; i++) begin
            if (i != bad_at) add_byte(pick_byte(8'h80, 8'hBF));
            else if ($urandom_range(0, 1) == 0) add_byte(pick_byte(8'h00, 8'h7F));
            else add_byte(pick_byte(8'hC0, 8'hFF));
          end
        end
        default: begin
          // Cut the sequence off with the end of the file.
          n = $urandom_range(2, 4);
          add_byte((n == 2) ? pick_byte(8'hC0, 8'hDF) :
                   (n == 3) ? pick_byte(8'hE0, 8'hEF) : pick_byte(8'hF0, 8'hF7));
          repeat ($urandom_range(0, n - 2)) add_byte(pick_byte(8'h00, 8'hFF));
          return;
        end
      endcase
      add_text($urandom_range(0, 6));
    end else begin
      repeat (len) add_byte(pick_byte(8'h00, 8'hFF));
    end
  endtask

  initial begin
    bytes_sent = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed files with text_mode at its reset value.
    file_q = '{8'h41};                   send_file();
    file_q = '{8'h80, 8'h00, 8'hFF};     send_file();
    file_q = '{8'hC3, 8'hA9};            send_file();
    file_q = '{8'hE2, 8'h82};            send_file();
    file_q = '{8'hE2, 8'h41, 8'h82};     send_file();
    file_q = '{8'hEF, 8'hBB, 8'hBF, 8'h11}; send_file();
    file_q = '{8'hEF, 8'hBB, 8'hBF, 8'hC3}; send_file();
    file_q = '{8'hEF, 8'hBB};            send_file();
    finish_phase();
    write_text_mode(1'b1);
    file_q = '{8'h80};                   send_file();
    file_q = '{8'hF0, 8'h90, 8'h80, 8'h80}; send_file();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      finish_phase();
      case (phase % 3)
        0:       write_text_mode(1'b0);
        1:       write_text_mode(1'b1);
        default: write_text_mode(1'($urandom_range(0, 1)));
      endcase
      calm = (phase == 2);
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        make_file();
        send_file();
      end
    end
    calm = 1'b0;
    finish_phase();
    repeat (8) @(negedge clk_i);

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
